/* hw/rtl/bhpq_pkg.sv */
package bhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_W      = 7;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  function automatic logic word_less(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

/* hw/rtl/bhpq_ram.sv */
module bhpq_ram #(
  parameter int unsigned DEPTH = bhpq_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bhpq_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]               raddr_a,
  input  logic [AW-1:0]               raddr_b,
  output logic [bhpq_pkg::DATA_W-1:0] rdata_a,
  output logic [bhpq_pkg::DATA_W-1:0] rdata_b
);
  import bhpq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/binary_max_heap_priority_queue_unit.sv */
// Binary max-heap of signed 32-bit values held in one two-read-port memory.
// A push ends in its accept step when the heap is empty or full; else its steps are the accept,
// one per tree level climbed and, once the root is reached, the root write. A pop ends in its
// accept step when the heap is empty or the pop leaves it empty; else its steps are the accept,
// the fetch of the last entry and one per level visited. The strobe is registered: it rises in
// the cycle after the last step, busy low. Synchronous reset empties the heap, not the memory.
module binary_max_heap_priority_queue_unit #(
  parameter int unsigned CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [bhpq_pkg::DATA_W-1:0] value,
  output logic                        done,
  output logic [bhpq_pkg::DATA_W-1:0] max_value,
  output logic                        is_empty,
  output logic [bhpq_pkg::COUNT_W-1:0] entry_count,
  output logic [1:0]                  status
);
  import bhpq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = IW + 2;

  typedef enum logic [2:0] {
    IDLE,
    PUSH_CHK,
    PLACE,
    POP_LAST,
    POP_CHK
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic [IW-1:0]     pos;
  logic [IW-1:0]     ppos;
  logic [DATA_W-1:0] hold;
  logic [DATA_W-1:0] root;
  logic [1:0]        stat;
  logic              strobe;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [IW-1:0]     ra;
  logic [IW-1:0]     rb;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;

  logic [KW-1:0]     cnt_k;
  logic [CW-1:0]     cnt_m1;
  logic [KW-1:0]     left;
  logic [KW-1:0]     right;
  logic              take_r;
  logic [DATA_W-1:0] best_val;
  logic [IW-1:0]     best_idx;
  logic              move_down;
  logic              move_up;
  logic [CW+COUNT_W-1:0] cnt_ext;

  function automatic logic [IW-1:0] parent_of(input logic [IW-1:0] p);
    return (p - IW'(1)) >> 1;
  endfunction

  function automatic logic [KW-1:0] left_of(input logic [IW-1:0] p);
    return {1'b0, p, 1'b1};
  endfunction

  function automatic logic [IW-1:0] addr_of(input logic [KW-1:0] c);
    return (c < KW'(CAPACITY)) ? c[IW-1:0] : '0;
  endfunction

  bhpq_ram #(
    .DEPTH(CAPACITY),
    .AW   (IW)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(ra),
    .raddr_b(rb),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  assign cnt_k     = KW'(cnt);
  assign cnt_m1    = cnt - CW'(1);
  assign left      = left_of(pos);
  assign right     = left + KW'(1);
  assign take_r    = (right < cnt_k) && word_less(rdata_a, rdata_b);
  assign best_val  = take_r ? rdata_b : rdata_a;
  assign best_idx  = take_r ? right[IW-1:0] : left[IW-1:0];
  assign move_down = (left < cnt_k) && word_less(hold, best_val);
  assign move_up   = word_less(rdata_a, hold);

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = hold;
    ra    = '0;
    rb    = '0;
    unique case (state)
      IDLE: begin
        if (start) begin
          if (req_type == REQ_PUSH) begin
            ra = parent_of(cnt[IW-1:0]);
            if (cnt == '0) begin
              we    = 1'b1;
              waddr = '0;
              wdata = value;
            end
          end else begin
            ra = cnt_m1[IW-1:0];
          end
        end
      end
      PUSH_CHK: begin
        we = 1'b1;
        if (move_up) begin
          wdata = rdata_a;
          ra    = parent_of(ppos);
        end
      end
      PLACE: begin
        we = 1'b1;
      end
      POP_LAST: begin
        ra = addr_of(left_of('0));
        rb = addr_of(left_of('0) + KW'(1));
      end
      POP_CHK: begin
        we = 1'b1;
        if (move_down) begin
          wdata = best_val;
          ra    = addr_of(left_of(best_idx));
          rb    = addr_of(left_of(best_idx) + KW'(1));
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      cnt    <= '0;
      stat   <= ST_OK;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (we && (waddr == '0)) begin
        root <= wdata;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            if (req_type == REQ_PUSH) begin
              if (cnt >= CW'(CAPACITY)) begin
                stat   <= ST_OVERFLOW;
                strobe <= 1'b1;
              end else begin
                cnt  <= cnt + CW'(1);
                hold <= value;
                pos  <= cnt[IW-1:0];
                ppos <= parent_of(cnt[IW-1:0]);
                if (cnt == '0) begin
                  stat   <= ST_OK;
                  strobe <= 1'b1;
                end else begin
                  state <= PUSH_CHK;
                end
              end
            end else begin
              if (cnt == '0) begin
                stat   <= ST_UNDERFLOW;
                strobe <= 1'b1;
              end else begin
                cnt <= cnt_m1;
                if (cnt == CW'(1)) begin
                  stat   <= ST_OK;
                  strobe <= 1'b1;
                end else begin
                  state <= POP_LAST;
                end
              end
            end
          end
        end
        PUSH_CHK: begin
          if (move_up) begin
            pos <= ppos;
            if (ppos == '0) begin
              state <= PLACE;
            end else begin
              ppos <= parent_of(ppos);
            end
          end else begin
            stat   <= ST_OK;
            strobe <= 1'b1;
            state  <= IDLE;
          end
        end
        PLACE: begin
          stat   <= ST_OK;
          strobe <= 1'b1;
          state  <= IDLE;
        end
        POP_LAST: begin
          hold  <= rdata_a;
          pos   <= '0;
          state <= POP_CHK;
        end
        POP_CHK: begin
          if (move_down) begin
            pos <= best_idx;
          end else begin
            stat   <= ST_OK;
            strobe <= 1'b1;
            state  <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign cnt_ext     = {{COUNT_W{1'b0}}, cnt};
  assign busy        = (state != IDLE);
  assign done        = strobe;
  assign max_value   = (cnt != '0) ? root : '0;
  assign is_empty    = (cnt == '0);
  assign entry_count = cnt_ext[COUNT_W-1:0];
  assign status      = stat;

endmodule
